// ===== rtl/tcrc_pkg.sv =====
// Shared types, codes and the byte-wide CRC-32 update for the table CRC checker.
`default_nettype none

package tcrc_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_VERIFY  = 1'b1;

    typedef enum logic [1:0] {
        ST_CAPTURED = 2'd0,
        ST_MATCH    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_NOT_INIT = 2'd3
    } status_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] table_index;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  result_table;
        logic [31:0] crc_value;
        logic [1:0]  status;
        logic        any_corrupted;
        logic [2:0]  first_bad_table;
        logic        first_bad_valid;
    } result_t;

    // Commands from the top level to the reference store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_cmd_t;

    // Reflected CRC-32 over one byte, one shift per bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcrc_ref_store.sv =====
// Reference CRC memory with per-table valid bits and registered read data.
`default_nettype none

module tcrc_ref_store #(
    parameter int TABLE_COUNT = 7,
    parameter int AW          = 3
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  tcrc_pkg::store_cmd_t cmd,
    input  wire [AW-1:0]         addr,
    input  wire [31:0]           wr_data,
    output logic [31:0]          rd_data,
    output logic                 rd_valid
);

    logic [31:0]            mem [TABLE_COUNT];
    logic [TABLE_COUNT-1:0] valid_reg;
    logic [TABLE_COUNT-1:0] valid_next;
    logic [31:0]            rd_data_reg;
    logic                   rd_valid_reg;

    // The memory has no reset; a read returns the entry's valid bit on rd_valid with the data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr_en)
            valid_next[addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/table_crc_reference_checker.sv =====
// Top level of the table CRC reference checker: CRC datapath, compare stage, result register.
`default_nettype none

// Usage
// The item channel (item_valid, item_ready, item) carries one table byte per request,
// tagged with its table index, a capture or verify mode and a last-byte mark. A reflected
// CRC-32 runs over consecutive bytes; the mode and index of the last byte decide what
// happens to the finished CRC. The result channel (result_valid, result_ready, result)
// delivers one request per last byte: the table index, the final CRC, a status code and
// the sticky corruption flags. Bytes that are not last produce nothing.
// Throughput is one byte per clock while item_ready is high. The byte-wide CRC update
// completes in the accepting cycle; capture writes and verify reads of the reference
// memory are issued in that same cycle. The compare stage then checks the registered read
// data, and its result is registered into the result register, which drives result_valid.
// When the receiver stalls, the result register holds and the compare stage keeps one
// more result; item_ready falls only when both are full, so up to two results wait.
// Reset clears the running CRC to all ones, all reference valid bits, the corruption flag
// and the first-bad record. The reference memory itself is not cleared, so there is no
// clearing pass and the block accepts bytes right after reset.
module table_crc_reference_checker #(
    parameter int TABLE_COUNT = 7
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_ready,
    input  tcrc_pkg::item_t    item,
    output logic               result_valid,
    input  wire                result_ready,
    output tcrc_pkg::result_t  result
);

    localparam int AW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int IW = 3;

    // Running CRC over the current table.
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_upd;

    logic             item_accept;
    logic             in_range;
    logic [IW+AW-1:0] idx_wide;
    logic [AW-1:0]    addr;

    tcrc_pkg::store_cmd_t store_cmd;
    logic [31:0]          ref_data;
    logic                 ref_valid;

    // Compare stage: one finished table waiting for its reference read.
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_mode_reg;
    logic [2:0]  s1_idx_reg;
    logic [31:0] s1_crc_reg;
    logic        s1_in_range_reg;
    logic        s1_advance;

    // Sticky flags.
    logic       corrupted_reg, corrupted_next;
    logic       first_bad_seen_reg, first_bad_seen_next;
    logic [2:0] first_bad_index_reg, first_bad_index_next;

    logic              result_valid_reg, result_valid_next;
    tcrc_pkg::result_t result_reg;
    tcrc_pkg::status_t s1_status;

    assign s1_advance  = !result_valid_reg || result_ready;
    assign item_ready  = !s1_valid_reg || s1_advance;
    assign item_accept = item_valid && item_ready;

    assign crc_upd  = tcrc_pkg::crc_byte(crc_reg, item.data_byte);
    assign in_range = (32'(item.table_index) < TABLE_COUNT);
    assign idx_wide = {{AW{1'b0}}, item.table_index};
    // Only meaningful when in_range, so the truncation never drops a set bit.
    assign addr     = idx_wide[AW-1:0];

    always_comb
    begin
        crc_next = crc_reg;
        if (item_accept)
            crc_next = item.last_byte ? tcrc_pkg::CRC_INIT : crc_upd;
    end

    // Captures are written and verifies are read in the accepting cycle, so memory
    // accesses stay in request order and no forwarding is needed.
    always_comb
    begin
        store_cmd.wr_en = item_accept && item.last_byte && in_range
                          && (item.mode == tcrc_pkg::MODE_CAPTURE);
        store_cmd.rd_en = item_accept && item.last_byte && in_range
                          && (item.mode == tcrc_pkg::MODE_VERIFY);
    end

    tcrc_ref_store #(
        .TABLE_COUNT (TABLE_COUNT),
        .AW          (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (store_cmd),
        .addr     (addr),
        .wr_data  (~crc_upd),
        .rd_data  (ref_data),
        .rd_valid (ref_valid)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
            s1_valid_next = item.last_byte;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    // Classify the finished table against its reference.
    always_comb
    begin
        if (!s1_in_range_reg)
            s1_status = tcrc_pkg::ST_NOT_INIT;
        else if (s1_mode_reg == tcrc_pkg::MODE_CAPTURE)
            s1_status = tcrc_pkg::ST_CAPTURED;
        else if (!ref_valid)
            s1_status = tcrc_pkg::ST_NOT_INIT;
        else if (ref_data == s1_crc_reg)
            s1_status = tcrc_pkg::ST_MATCH;
        else
            s1_status = tcrc_pkg::ST_MISMATCH;
    end

    always_comb
    begin
        corrupted_next       = corrupted_reg;
        first_bad_seen_next  = first_bad_seen_reg;
        first_bad_index_next = first_bad_index_reg;
        if (s1_valid_reg && s1_advance && (s1_status == tcrc_pkg::ST_MISMATCH))
        begin
            corrupted_next = 1'b1;
            if (!first_bad_seen_reg)
            begin
                first_bad_seen_next  = 1'b1;
                first_bad_index_next = s1_idx_reg;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_advance)
            result_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg             <= tcrc_pkg::CRC_INIT;
            s1_valid_reg        <= 1'b0;
            result_valid_reg    <= 1'b0;
            corrupted_reg       <= 1'b0;
            first_bad_seen_reg  <= 1'b0;
            first_bad_index_reg <= 3'd0;
        end
        else
        begin
            crc_reg             <= crc_next;
            s1_valid_reg        <= s1_valid_next;
            result_valid_reg    <= result_valid_next;
            corrupted_reg       <= corrupted_next;
            first_bad_seen_reg  <= first_bad_seen_next;
            first_bad_index_reg <= first_bad_index_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_accept && item.last_byte)
        begin
            s1_mode_reg     <= item.mode;
            s1_idx_reg      <= item.table_index;
            s1_crc_reg      <= ~crc_upd;
            s1_in_range_reg <= in_range;
        end
        if (s1_valid_reg && s1_advance)
        begin
            result_reg.result_table    <= s1_idx_reg;
            result_reg.crc_value       <= s1_crc_reg;
            result_reg.status          <= s1_status;
            result_reg.any_corrupted   <= corrupted_next;
            result_reg.first_bad_table <= first_bad_index_next;
            result_reg.first_bad_valid <= first_bad_seen_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A mismatch reported on the output must already show in the sticky flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == tcrc_pkg::ST_MISMATCH)
        |-> result.any_corrupted && result.first_bad_valid)
    else $error("mismatch result without corruption flags");

    // The corruption flag never clears once set.
    assert property (@(posedge clk) disable iff (!rst_n)
        corrupted_reg |=> corrupted_reg)
    else $error("corruption flag cleared");

    // The first bad table is recorded once and then held.
    assert property (@(posedge clk) disable iff (!rst_n)
        first_bad_seen_reg |=> first_bad_seen_reg && $stable(first_bad_index_reg))
    else $error("first bad table record changed");

    // A last byte always enters the compare stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && item.last_byte |=> s1_valid_reg)
    else $error("last byte lost before compare stage");

    // The running CRC restarts after every last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && item.last_byte |=> crc_reg == tcrc_pkg::CRC_INIT)
    else $error("running CRC not restarted");

endmodule

`default_nettype wire

// ===== sim/table_crc_reference_checker_tb.sv =====
// Self-checking testbench for the table CRC reference checker: directed table, then random tables.
module table_crc_reference_checker_tb;

    localparam int TABLE_COUNT      = 7;
    // Random part, spread evenly over the four idling phases.
    localparam int RANDOM_ITEMS     = 800;
    // Cycles with no request on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT   = 2000;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int LONG_HOLD_CYCLES = 80;
    // Cycles waited after the last expected result has left, to catch strays.
    localparam int DRAIN_CYCLES     = 8;

    // A row of the directed table: one request, and optionally the result it must give,
    // typed in by hand where it can be read off without computing a CRC.
    typedef struct {
        tcrc_pkg::item_t   req;
        bit                checked;
        tcrc_pkg::result_t want;
    } directed_row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    tcrc_pkg::item_t   item         = '0;
    logic              result_ready = 1'b0;
    wire               item_ready;
    wire               result_valid;
    tcrc_pkg::result_t result;

    // The hand-typed expectation travels with the request on the same edges, so the
    // monitor always sees the pair that belongs together.
    bit                req_checked  = 1'b0;
    tcrc_pkg::result_t req_want     = '0;

    // Predictor state: running CRC, reference store and the sticky corruption record.
    logic [31:0] crc_run;
    logic [31:0] ref_crc [0:7];
    bit          ref_ok [0:7];
    bit          corrupt_seen;
    logic [2:0]  bad_table;
    bit          bad_seen;

    tcrc_pkg::result_t crc_results_due [$];
    directed_row_t     directed_rows [$];

    // Stimulus-side copy of the bytes last captured per table, so verify passes can
    // replay a table exactly (match) or with one bit flipped (mismatch).
    logic [7:0] image_bytes [0:7][0:15];
    int         image_len [0:7];

    int failures              = 0;
    int idle_cycles           = 0;
    int sender_idle_pct       = 0;
    int receiver_stall_pct    = 0;
    int long_holds_requested  = 0;
    int long_holds_served     = 0;
    int random_items_sent     = 0;

    table_crc_reference_checker #(
        .TABLE_COUNT(TABLE_COUNT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Reflected CRC-32 fed one data bit at a time: the low bit of the register, xored
    // with the incoming bit, decides whether the polynomial is folded in.
    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            r = (r >> 1) ^ ((r[0] ^ b[k]) ? tcrc_pkg::CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    // Advances the predictor by one accepted byte. Returns 1 and fills the expected
    // result when the byte closes a table, 0 for bytes in the middle of a table.
    function automatic bit table_crc_step(input tcrc_pkg::item_t req,
                                          output tcrc_pkg::result_t r);
        logic [31:0]       fin;
        logic [2:0]        idx;
        tcrc_pkg::status_t st;
        r       = '0;
        idx     = req.table_index;
        crc_run = crc32_next(crc_run, req.data_byte);
        if (!req.last_byte)
            return 1'b0;
        fin     = ~crc_run;
        crc_run = tcrc_pkg::CRC_INIT;
        // Out-of-range tables neither store nor compare, whatever the mode.
        if (idx >= TABLE_COUNT)
            st = tcrc_pkg::ST_NOT_INIT;
        else if (req.mode == tcrc_pkg::MODE_CAPTURE)
        begin
            ref_crc[idx] = fin;
            ref_ok[idx]  = 1'b1;
            st           = tcrc_pkg::ST_CAPTURED;
        end
        else if (!ref_ok[idx])
            st = tcrc_pkg::ST_NOT_INIT;
        else if (ref_crc[idx] == fin)
            st = tcrc_pkg::ST_MATCH;
        else
        begin
            st           = tcrc_pkg::ST_MISMATCH;
            corrupt_seen = 1'b1;
            // Only the first mismatching table is recorded; later ones leave it alone.
            if (!bad_seen)
            begin
                bad_seen  = 1'b1;
                bad_table = idx;
            end
        end
        r.result_table    = idx;
        r.crc_value       = fin;
        r.status          = st;
        r.any_corrupted   = corrupt_seen;
        r.first_bad_table = bad_seen ? bad_table : 3'd0;
        r.first_bad_valid = bad_seen;
        return 1'b1;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s differs: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        failures++;
    endtask

    // Monitor. Requests are sampled at the rising edge, before any of this edge's
    // updates land, so both channels see the values that were actually handshaken.
    always @(posedge clk)
    begin
        tcrc_pkg::result_t predicted;
        tcrc_pkg::result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                if (table_crc_step(item, predicted))
                    crc_results_due.push_back(req_checked ? req_want : predicted);
            end
            if (result_valid && result_ready)
            begin
                if (crc_results_due.size() == 0)
                begin
                    $display("%0t: result with none expected: expected nothing, actual %p",
                             $time, result);
                    failures++;
                end
                else
                begin
                    want = crc_results_due.pop_front();
                    if (result.result_table !== want.result_table)
                        report_field("result_table", want.result_table, result.result_table);
                    if (result.crc_value !== want.crc_value)
                        report_field("crc_value", want.crc_value, result.crc_value);
                    if (result.status !== want.status)
                        report_field("status", want.status, result.status);
                    if (result.any_corrupted !== want.any_corrupted)
                        report_field("any_corrupted", want.any_corrupted, result.any_corrupted);
                    if (result.first_bad_table !== want.first_bad_table)
                        report_field("first_bad_table", want.first_bad_table,
                                     result.first_bad_table);
                    if (result.first_bad_valid !== want.first_bad_valid)
                        report_field("first_bad_valid", want.first_bad_valid,
                                     result.first_bad_valid);
                end
            end
        end
    end

    // Watchdog: a run that stops moving on both channels is a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver. Stalls at random at the current phase's rate, and serves each long
    // hold-off request by keeping ready low for the whole hold-off.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_holds_served < long_holds_requested)
            begin
                long_holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offers one request and returns at the edge where it is accepted. Random idle
    // cycles come first; when there are none, valid simply stays high into the next
    // request so back-to-back bytes go through at full rate.
    task automatic send_item(input tcrc_pkg::item_t req, input bit checked,
                             input tcrc_pkg::result_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        item        <= req;
        req_checked <= checked;
        req_want    <= want;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic void add_row(input tcrc_pkg::item_t req);
        directed_row_t row;
        row.req     = req;
        row.checked = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked_row(input tcrc_pkg::item_t req,
                                            input tcrc_pkg::result_t want);
        directed_row_t row;
        row.req     = req;
        row.checked = 1'b1;
        row.want    = want;
        directed_rows.push_back(row);
    endfunction

    // One well-formed table: a run of bytes closed by a last byte. Verify passes on a
    // table that has a captured image mostly replay it, sometimes with one bit flipped.
    // Bytes before the last one carry random mode and index, which must not matter.
    task automatic send_random_table();
        tcrc_pkg::item_t req;
        logic [2:0]      idx;
        logic            md;
        int              len;
        logic [7:0]      body [0:15];
        idx = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(TABLE_COUNT - 1));
        md  = ($urandom_range(99) < 35) ? tcrc_pkg::MODE_CAPTURE : tcrc_pkg::MODE_VERIFY;
        if (md == tcrc_pkg::MODE_VERIFY && idx < TABLE_COUNT && image_len[idx] > 0
            && $urandom_range(99) < 75)
        begin
            len = image_len[idx];
            for (int k = 0; k < len; k++)
                body[k] = image_bytes[idx][k];
            if ($urandom_range(2) == 0)
                body[$urandom_range(len - 1)] ^= 8'(1 << $urandom_range(7));
        end
        else
        begin
            // Mostly short tables, now and then the longest one the image can hold.
            len = ($urandom_range(19) == 0) ? 16 : $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                body[k] = 8'($urandom);
        end
        if (md == tcrc_pkg::MODE_CAPTURE && idx < TABLE_COUNT)
        begin
            image_len[idx] = len;
            for (int k = 0; k < len; k++)
                image_bytes[idx][k] = body[k];
        end
        for (int k = 0; k < len; k++)
        begin
            req.last_byte   = (k == len - 1);
            req.mode        = req.last_byte ? md : 1'($urandom);
            req.table_index = req.last_byte ? idx : 3'($urandom);
            req.data_byte   = body[k];
            send_item(req, 1'b0, '0);
            random_items_sent++;
        end
    endtask

    initial
    begin : stimulus
        tcrc_pkg::item_t req;
        int              phase_goal;

        crc_run      = tcrc_pkg::CRC_INIT;
        corrupt_seen = 1'b0;
        bad_table    = 3'd0;
        bad_seen     = 1'b0;
        for (int t = 0; t < 8; t++)
        begin
            ref_crc[t]   = '0;
            ref_ok[t]    = 1'b0;
            image_len[t] = 0;
        end

        // Directed table. A single 0x00 byte has CRC 0xD202EF8D and a single 0xFF byte
        // 0xFF000000; the nine ASCII digits give the well-known check value 0xCBF43926.
        // Verify before any capture, then capture, match and a first mismatch on table 6.
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd6, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd6, 32'hD202EF8D, tcrc_pkg::ST_NOT_INIT,
                                            1'b0, 3'd0, 1'b0});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd6, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd6, 32'hD202EF8D, tcrc_pkg::ST_CAPTURED,
                                            1'b0, 3'd0, 1'b0});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd6, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd6, 32'hD202EF8D, tcrc_pkg::ST_MATCH,
                                            1'b0, 3'd0, 1'b0});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd6, 8'hFF, 1'b1},
                        tcrc_pkg::result_t'{3'd6, 32'hFF000000, tcrc_pkg::ST_MISMATCH,
                                            1'b1, 3'd6, 1'b1});
        // A later mismatch on table 0 keeps table 6 as the first bad one.
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd0, 8'hFF, 1'b1},
                        tcrc_pkg::result_t'{3'd0, 32'hFF000000, tcrc_pkg::ST_CAPTURED,
                                            1'b1, 3'd6, 1'b1});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd0, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd0, 32'hD202EF8D, tcrc_pkg::ST_MISMATCH,
                                            1'b1, 3'd6, 1'b1});
        // Index past the last table: nothing stored or compared in either mode.
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd7, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd7, 32'hD202EF8D, tcrc_pkg::ST_NOT_INIT,
                                            1'b1, 3'd6, 1'b1});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd7, 8'hFF, 1'b1},
                        tcrc_pkg::result_t'{3'd7, 32'hFF000000, tcrc_pkg::ST_NOT_INIT,
                                            1'b1, 3'd6, 1'b1});
        // A multi-byte table whose earlier bytes carry stray modes and indexes.
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd7, 8'h31, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd2, 8'h32, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd5, 8'h33, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd0, 8'h34, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd1, 8'h35, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd4, 8'h36, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd3, 8'h37, 1'b0});
        add_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd6, 8'h38, 1'b0});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd3, 8'h39, 1'b1},
                        tcrc_pkg::result_t'{3'd3, 32'hCBF43926, tcrc_pkg::ST_CAPTURED,
                                            1'b1, 3'd6, 1'b1});
        // Capture over a valid reference overwrites it, and the new one then matches.
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_CAPTURE, 3'd0, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd0, 32'hD202EF8D, tcrc_pkg::ST_CAPTURED,
                                            1'b1, 3'd6, 1'b1});
        add_checked_row(tcrc_pkg::item_t'{tcrc_pkg::MODE_VERIFY, 3'd0, 8'h00, 1'b1},
                        tcrc_pkg::result_t'{3'd0, 32'hD202EF8D, tcrc_pkg::ST_MATCH,
                                            1'b1, 3'd6, 1'b1});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_item(directed_rows[n].req, directed_rows[n].checked, directed_rows[n].want);

        // Random part in four phases: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 52;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 52;
                end
                default:
                begin
                    sender_idle_pct    = 32;
                    receiver_stall_pct = 32;
                end
            endcase
            phase_goal = (RANDOM_ITEMS / 4) * (ph + 1);

            // In the first phase the receiver holds off for a long stretch while the
            // sender keeps offering one-byte tables, so both result slots fill up and
            // the block has to drop item_ready.
            if (ph == 0)
            begin
                long_holds_requested++;
                repeat (40)
                begin
                    req             = tcrc_pkg::item_t'($urandom);
                    req.table_index = 3'($urandom_range(TABLE_COUNT - 1));
                    req.last_byte   = 1'b1;
                    send_item(req, 1'b0, '0);
                    random_items_sent++;
                end
            end

            while (random_items_sent < phase_goal)
            begin
                // About one time in ten a single noise request goes instead of a table: every field
                // random, including the last-byte mark, so tables get broken up or merged.
                if ($urandom_range(9) == 0)
                begin
                    send_item(tcrc_pkg::item_t'($urandom), 1'b0, '0);
                    random_items_sent++;
                end
                else
                    send_random_table();
            end
        end

        item_valid <= 1'b0;
        while (crc_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcrc_pkg.sv
rtl/tcrc_ref_store.sv
rtl/table_crc_reference_checker.sv
sim/table_crc_reference_checker_tb.sv
